/* src/assert_macros.svh */
// Assertion macros for the RTL files.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: label");
// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* src/bpc_pkg.sv */
// Shared types and constants of the button press classifier.
// No dependencies; imported by all modules of the block.
`default_nettype none
package bpc_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_W       = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    localparam longint unsigned TIMER_MAX_L = (64'd1 << TIMER_WIDTH) - 64'd1;
    localparam longint unsigned PRESET_L    = (TIMER_MAX_L > 64'd8191) ? 64'd8191 : TIMER_MAX_L;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX   = TIMER_MAX_L[TIMER_WIDTH-1:0];
    localparam logic [TIMER_WIDTH-1:0] IDLE_PRESET = PRESET_L[TIMER_WIDTH-1:0];

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_TICK_INTERVAL = 3'd0,
        REG_IDLE_TIMEOUT  = 3'd1,
        REG_REPORT_DELAY  = 3'd2,
        REG_MIN_PRESS     = 3'd3,
        REG_SHORT_HOLD    = 3'd4,
        REG_LONG_HOLD     = 3'd5,
        REG_TIMER_LIMIT   = 3'd6,
        REG_ENABLE_MASK   = 3'd7
    } reg_index_t;

    localparam logic [CFG_WIDTH-1:0] RST_TICK_INTERVAL = 16'd20;
    localparam logic [CFG_WIDTH-1:0] RST_IDLE_TIMEOUT  = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] RST_REPORT_DELAY  = 16'd300;
    localparam logic [CFG_WIDTH-1:0] RST_MIN_PRESS     = 16'd20;
    localparam logic [CFG_WIDTH-1:0] RST_SHORT_HOLD    = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] RST_LONG_HOLD     = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] RST_TIMER_LIMIT   = 16'd8192;
    localparam logic [3:0]           RST_ENABLE_MASK   = 4'hF;

    // enable_mask bit positions
    localparam int EN_SINGLE_BIT = 0;
    localparam int EN_MULTI_BIT  = 1;
    localparam int EN_SHORT_BIT  = 2;
    localparam int EN_LONG_BIT   = 3;

    typedef enum logic [3:0] {
        EV_UNDEF  = 4'd0,
        EV_IDLE   = 4'd1,
        EV_BUSY   = 4'd2,
        EV_ERROR  = 4'd3,
        EV_SINGLE = 4'd4,
        EV_DOUBLE = 4'd5,
        EV_TRIPLE = 4'd6,
        EV_SHORT  = 4'd7,
        EV_LONG   = 4'd8
    } event_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] tick_interval;
        logic [CFG_WIDTH-1:0] idle_timeout;
        logic [CFG_WIDTH-1:0] report_delay;
        logic [CFG_WIDTH-1:0] min_press_time;
        logic [CFG_WIDTH-1:0] short_hold_time;
        logic [CFG_WIDTH-1:0] long_hold_time;
        logic [CFG_WIDTH-1:0] timer_limit;
        logic [3:0]           enable_mask;
    } cfg_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } obuf_status_t;

endpackage
`default_nettype wire

/* src/button_press_classifier_unit.sv */
// Top level of the button press classifier: APB registers, core, result buffer.
// Depends on bpc_pkg, bpc_regs, bpc_core, bpc_obuf and assert_macros.svh.
//
// One input beat (button sample plus tick flag) yields exactly one event code
// beat. Each beat is classified in the cycle it is accepted and its result is
// registered, so the block takes one beat per clock; the only stall comes from
// the two-entry result buffer filling when m_ready is held low. m_valid is
// high in the cycle after an input is accepted. Configure only while no beats
// are in flight; pready is always high and reads return the register contents.
`default_nettype none
`include "assert_macros.svh"
module button_press_classifier_unit
    import bpc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_button_level,
    input  wire logic               s_tick_due,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [3:0]         m_event_code
);

    cfg_t         cfg;
    event_t       core_event;
    logic         accept;
    logic         can_push;
    obuf_status_t obuf_status;

    assign s_ready = can_push;
    assign accept  = s_valid && s_ready;

    bpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .accept       (accept),
        .button_level (s_button_level),
        .tick_due     (s_tick_due),
        .event_out    (core_event)
    );

    bpc_obuf u_obuf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (accept),
        .push_event   (core_event),
        .can_push     (can_push),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .status       (obuf_status)
    );

    `ASSERT_ALWAYS(a_skid_needs_out, aclk, obuf_status.skid_valid |-> obuf_status.out_valid)
    `ASSERT_CLK(a_stall_only_when_full, aclk, aresetn, !s_ready |-> m_valid && !m_ready || m_valid)
    `ASSERT_CLK(a_accept_gives_result, aclk, aresetn, accept |=> m_valid)
    `ASSERT_CLK(a_code_in_range, aclk, aresetn, m_valid |-> (m_event_code <= EV_LONG))

endmodule
`default_nettype wire

/* src/bpc_regs.sv */
// APB configuration registers of the button press classifier.
// Depends on bpc_pkg.
`default_nettype none
module bpc_regs
    import bpc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_interval   <= RST_TICK_INTERVAL;
            cfg_reg.idle_timeout    <= RST_IDLE_TIMEOUT;
            cfg_reg.report_delay    <= RST_REPORT_DELAY;
            cfg_reg.min_press_time  <= RST_MIN_PRESS;
            cfg_reg.short_hold_time <= RST_SHORT_HOLD;
            cfg_reg.long_hold_time  <= RST_LONG_HOLD;
            cfg_reg.timer_limit     <= RST_TIMER_LIMIT;
            cfg_reg.enable_mask     <= RST_ENABLE_MASK;
        end else if (wr_en) begin
            case (idx)
                REG_TICK_INTERVAL: cfg_reg.tick_interval   <= pwdata[CFG_WIDTH-1:0];
                REG_IDLE_TIMEOUT:  cfg_reg.idle_timeout    <= pwdata[CFG_WIDTH-1:0];
                REG_REPORT_DELAY:  cfg_reg.report_delay    <= pwdata[CFG_WIDTH-1:0];
                REG_MIN_PRESS:     cfg_reg.min_press_time  <= pwdata[CFG_WIDTH-1:0];
                REG_SHORT_HOLD:    cfg_reg.short_hold_time <= pwdata[CFG_WIDTH-1:0];
                REG_LONG_HOLD:     cfg_reg.long_hold_time  <= pwdata[CFG_WIDTH-1:0];
                REG_TIMER_LIMIT:   cfg_reg.timer_limit     <= pwdata[CFG_WIDTH-1:0];
                REG_ENABLE_MASK:   cfg_reg.enable_mask     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TICK_INTERVAL: prdata = PDATA_W'(cfg_reg.tick_interval);
            REG_IDLE_TIMEOUT:  prdata = PDATA_W'(cfg_reg.idle_timeout);
            REG_REPORT_DELAY:  prdata = PDATA_W'(cfg_reg.report_delay);
            REG_MIN_PRESS:     prdata = PDATA_W'(cfg_reg.min_press_time);
            REG_SHORT_HOLD:    prdata = PDATA_W'(cfg_reg.short_hold_time);
            REG_LONG_HOLD:     prdata = PDATA_W'(cfg_reg.long_hold_time);
            REG_TIMER_LIMIT:   prdata = PDATA_W'(cfg_reg.timer_limit);
            REG_ENABLE_MASK:   prdata = PDATA_W'(cfg_reg.enable_mask);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* src/bpc_core.sv */
// Classifier state and next-state logic: timers, click count, hold tracking.
// Depends on bpc_pkg; state advances on every accepted input beat.
`default_nettype none
module bpc_core
    import bpc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cfg_t      cfg,
    input  wire logic accept,
    input  wire logic button_level,
    input  wire logic tick_due,
    output event_t    event_out
);

    logic                   prev_level_reg, prev_level_next;
    event_t                 last_event_reg, last_event_next;
    logic [TIMER_WIDTH-1:0] pressed_reg, pressed_next;
    logic [TIMER_WIDTH-1:0] released_reg, released_next;
    logic [7:0]             click_reg, click_next;
    logic [1:0]             hold_reg, hold_next;

    logic [CMP_W-1:0]       lim;
    logic [CMP_W-1:0]       p_ext, r_ext, pt, rt;
    logic [CMP_W:0]         p_sum, r_sum;
    logic                   go_idle;
    logic                   valid_click;

    function automatic logic [CMP_W-1:0] ext_t(input logic [TIMER_WIDTH-1:0] v);
        ext_t = CMP_W'(v);
    endfunction

    function automatic logic [CMP_W-1:0] ext_c(input logic [CFG_WIDTH-1:0] v);
        ext_c = CMP_W'(v);
    endfunction

    // Saturation limit is the smaller of timer_limit and the timer's range.
    assign lim = (ext_c(cfg.timer_limit) < ext_t(TIMER_MAX)) ?
                 ext_c(cfg.timer_limit) : ext_t(TIMER_MAX);

    assign p_ext = ext_t(pressed_reg);
    assign r_ext = ext_t(released_reg);
    assign p_sum = {1'b0, p_ext} + {1'b0, ext_c(cfg.tick_interval)};
    assign r_sum = {1'b0, r_ext} + {1'b0, ext_c(cfg.tick_interval)};

    // Only the timer matching the current level advances.
    always_comb begin
        pt = p_ext;
        rt = r_ext;
        if (!button_level) begin
            pt = (p_sum > {1'b0, lim}) ? lim : p_sum[CMP_W-1:0];
        end else begin
            rt = (r_sum > {1'b0, lim}) ? lim : r_sum[CMP_W-1:0];
        end
    end

    assign valid_click = pt >= ext_c(cfg.min_press_time);

    always_comb begin
        prev_level_next = prev_level_reg;
        pressed_next    = pressed_reg;
        released_next   = released_reg;
        click_next      = click_reg;
        hold_next       = hold_reg;
        go_idle         = 1'b0;
        // A reported event lasts one beat.
        last_event_next = (last_event_reg >= EV_SINGLE) ? EV_IDLE : last_event_reg;

        if (tick_due) begin
            last_event_next = EV_BUSY;
            pressed_next    = TIMER_WIDTH'(pt);
            released_next   = TIMER_WIDTH'(rt);

            if (!prev_level_reg && button_level) begin
                // release
                released_next = '0;
                if (pt > ext_c(cfg.short_hold_time)) begin
                    go_idle = 1'b1;
                end
            end else if (prev_level_reg && !button_level) begin
                // press
                if (click_reg != 8'd0 && !cfg.enable_mask[EN_MULTI_BIT] && valid_click) begin
                    last_event_next = EV_SINGLE;
                    go_idle         = 1'b1;
                end
                if (valid_click && click_reg != 8'hFF) begin
                    click_next = click_reg + 8'd1;
                end
                pressed_next = '0;
            end else if (button_level) begin
                // steady released
                if (rt >= ext_c(cfg.report_delay) && valid_click) begin
                    if (click_reg == 8'd1 && cfg.enable_mask[EN_SINGLE_BIT]) begin
                        last_event_next = EV_SINGLE;
                    end else if (click_reg == 8'd2 && cfg.enable_mask[EN_MULTI_BIT]) begin
                        last_event_next = EV_DOUBLE;
                    end
                    if (click_reg == 8'd3 && cfg.enable_mask[EN_MULTI_BIT]) begin
                        last_event_next = EV_TRIPLE;
                    end
                    go_idle = 1'b1;
                end
                if (rt > ext_c(cfg.idle_timeout)) begin
                    last_event_next = EV_IDLE;
                    click_next      = '0;
                end
            end else begin
                // steady pressed
                if (pt >= lim) begin
                    last_event_next = EV_ERROR;
                end else begin
                    released_next = '0;
                    if (pt > ext_c(cfg.short_hold_time) &&
                        (cfg.enable_mask[EN_SHORT_BIT] || cfg.enable_mask[EN_LONG_BIT])) begin
                        if (pt > ext_c(cfg.long_hold_time) && cfg.enable_mask[EN_LONG_BIT]) begin
                            if (hold_reg == 2'd1) begin
                                hold_next       = 2'd2;
                                last_event_next = EV_LONG;
                            end
                        end else if (hold_reg == 2'd0) begin
                            hold_next       = 2'd1;
                            last_event_next = EV_SHORT;
                        end
                    end
                end
            end

            if (go_idle) begin
                released_next = IDLE_PRESET;
                pressed_next  = '0;
                hold_next     = '0;
            end
            prev_level_next = button_level;
        end
    end

    assign event_out = last_event_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            last_event_reg <= EV_UNDEF;
            pressed_reg    <= '0;
            released_reg   <= TIMER_MAX;
            click_reg      <= '0;
            hold_reg       <= '0;
        end else if (accept) begin
            prev_level_reg <= prev_level_next;
            last_event_reg <= last_event_next;
            pressed_reg    <= pressed_next;
            released_reg   <= released_next;
            click_reg      <= click_next;
            hold_reg       <= hold_next;
        end
    end

endmodule
`default_nettype wire

/* src/bpc_obuf.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on bpc_pkg.
`default_nettype none
module bpc_obuf
    import bpc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  event_t      push_event,
    output logic        can_push,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic [3:0]  m_event_code,
    output obuf_status_t status
);

    logic   out_valid_reg, skid_valid_reg;
    event_t out_reg, skid_reg;
    logic   pop;

    assign pop          = out_valid_reg && m_ready;
    assign can_push     = !skid_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_event_code = out_reg;
    assign status       = '{out_valid: out_valid_reg, skid_valid: skid_valid_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= push_event;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_reg <= push_event;
            end else begin
                out_reg <= push_event;
            end
        end
    end

endmodule
`default_nettype wire
